@@ rtl/ppls_pkg.sv @@
// Shared widths, request types and arithmetic helpers for the point-light shading pipeline.
package ppls_pkg;

  localparam int COORD_BITS = 32;
  localparam int COLOR_BITS = 16;
  localparam int EXP_BITS   = 8;
  localparam int NORM_BITS  = 16;
  localparam int UNIT_FRAC  = 14;

  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int MAG_W     = DIFF_W;
  localparam int WIN_W     = 30;
  localparam int SQ_W      = 2 * WIN_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int NUM_W     = WIN_W + UNIT_FRAC + 1;
  localparam int DIV_STEPS = UNIT_FRAC + 1;
  localparam int SHIFT_W   = $clog2(MAG_W + 1);
  localparam int NORM_LAT  = 5 + ROOT_W + 1 + DIV_STEPS + 1;

  localparam int OUT_W     = COLOR_BITS + 1;
  localparam int DOT_W     = 2 * NORM_BITS + 2;
  localparam int DOT_FRAC  = 2 * UNIT_FRAC;
  localparam int POW_STEPS = (1 << EXP_BITS) - 1;
  localparam int TOTAL_LAT = 2 + NORM_LAT + 4 + NORM_LAT + 2 + POW_STEPS + 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RGB = 3'd6;

  localparam logic [OUT_W-1:0] UNIT_ONE = OUT_W'(1) << COLOR_BITS;
  localparam logic [OUT_W-1:0] SAT_MAX  = {OUT_W{1'b1}};

  typedef logic [2:0][DIFF_W-1:0]    dvec_t;
  typedef logic [2:0][NORM_BITS-1:0] uvec_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] hit_x;
    logic signed [COORD_BITS-1:0] hit_y;
    logic signed [COORD_BITS-1:0] hit_z;
    logic signed [NORM_BITS-1:0]  norm_x;
    logic signed [NORM_BITS-1:0]  norm_y;
    logic signed [NORM_BITS-1:0]  norm_z;
    logic [COLOR_BITS-1:0]        surf_red;
    logic [COLOR_BITS-1:0]        surf_green;
    logic [COLOR_BITS-1:0]        surf_blue;
    logic [COLOR_BITS-1:0]        diffuse_gain;
    logic [COLOR_BITS-1:0]        specular_gain;
    logic [EXP_BITS-1:0]          shine_exponent;
  } in_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] add_red;
    logic [OUT_W-1:0] add_green;
    logic [OUT_W-1:0] add_blue;
  } out_req_t;

  typedef struct packed {
    logic                    spen;
    logic [COLOR_BITS-1:0]   ks;
    logic [2:0][OUT_W-1:0]   diff;
  } pow_side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one radix-4 step of the digit-by-digit square root
  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] b);
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    sq_t o;
    r2    = {s.rem[REM_W-3:0], b};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

@@ rtl/ppls_norm.sv @@
// Pipelined vector normalizer: window shift, sum of squares, square root, per-lane divide.
module ppls_norm (
  input  logic            clk,
  input  logic            en,
  input  ppls_pkg::dvec_t vec,
  output ppls_pkg::uvec_t unit
);
  import ppls_pkg::*;

  typedef struct packed {
    logic [2:0][WIN_W-1:0] m;
    logic [2:0]            neg;
    logic                  zero;
  } carry_t;

  logic [2:0][MAG_W-1:0] mag_a_r, mag_b_r;
  logic [2:0]            neg_a_r, neg_b_r;
  logic                  zero_b_r;
  logic [SHIFT_W-1:0]    msb_b_r;
  logic [MAG_W-1:0]      mor;
  logic [SHIFT_W-1:0]    msb;
  logic [MAG_W-1:0]      sh [3];
  carry_t                car_c_nxt;
  carry_t                car_c_r, car_d_r, car_e_r, car_f_r;
  logic [2:0][SQ_W-1:0]  sq_d_r;
  logic [SUM_W-1:0]      sum_e_r;

  sq_t                   sq_r  [ROOT_W];
  logic [SUM_W-1:0]      x_r   [ROOT_W];
  carry_t                car_s_r [ROOT_W];

  logic [ROOT_W-1:0]     len_f_r;
  logic [2:0][NUM_W-1:0] num_f_r;

  logic [DIV_STEPS-1:0][2:0][NUM_W-1:0]     drem_r, drem_nxt, drem_in;
  logic [DIV_STEPS-1:0][2:0][DIV_STEPS-1:0] quo_r, quo_nxt, quo_in;
  logic [DIV_STEPS-1:0][NUM_W-1:0]          dcmp;
  logic [DIV_STEPS-1:0][ROOT_W-1:0]         dlen_r, dlen_in;
  logic [DIV_STEPS-1:0][2:0]                dneg_r;
  logic [DIV_STEPS-1:0]                     dzero_r;

  uvec_t unit_r;

  always_comb begin
    mor = mag_a_r[0] | mag_a_r[1] | mag_a_r[2];
    msb = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (mor[k]) begin
        msb = SHIFT_W'(k);
      end
    end
  end

  always_comb begin
    car_c_nxt.neg  = neg_b_r;
    car_c_nxt.zero = zero_b_r;
    for (int i = 0; i < 3; i++) begin
      if (msb_b_r >= SHIFT_W'(WIN_W)) begin
        sh[i] = mag_b_r[i] >> (msb_b_r - SHIFT_W'(WIN_W - 1));
      end else begin
        sh[i] = mag_b_r[i] << (SHIFT_W'(WIN_W - 1) - msb_b_r);
      end
      car_c_nxt.m[i] = sh[i][WIN_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        dlen_in[k] = len_f_r;
        drem_in[k] = num_f_r;
        quo_in[k]  = '0;
      end else begin
        dlen_in[k] = dlen_r[k-1];
        drem_in[k] = drem_r[k-1];
        quo_in[k]  = quo_r[k-1];
      end
      dcmp[k] = NUM_W'(dlen_in[k]) << (DIV_STEPS - 1 - k);
      for (int i = 0; i < 3; i++) begin
        quo_nxt[k][i] = quo_in[k][i];
        if (drem_in[k][i] >= dcmp[k]) begin
          drem_nxt[k][i] = drem_in[k][i] - dcmp[k];
          quo_nxt[k][i][DIV_STEPS-1-k] = 1'b1;
        end else begin
          drem_nxt[k][i] = drem_in[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_a_r[i] <= vec[i][DIFF_W-1];
        mag_a_r[i] <= vec[i][DIFF_W-1] ? (~vec[i] + MAG_W'(1)) : vec[i];
        sq_d_r[i]  <= SQ_W'(car_c_r.m[i]) * SQ_W'(car_c_r.m[i]);
        num_f_r[i] <= {car_s_r[ROOT_W-1].m[i], UNIT_FRAC'(0)}
                      + NUM_W'(sq_r[ROOT_W-1].root >> 1);
      end
      mag_b_r  <= mag_a_r;
      neg_b_r  <= neg_a_r;
      zero_b_r <= (mor == '0);
      msb_b_r  <= msb;
      car_c_r  <= car_c_nxt;
      car_d_r  <= car_c_r;
      car_e_r  <= car_d_r;
      sum_e_r  <= SUM_W'(sq_d_r[0]) + SUM_W'(sq_d_r[1]) + SUM_W'(sq_d_r[2]);

      sq_r[0]    <= sqrt_step('0, sum_e_r[SUM_W-1 -: 2]);
      x_r[0]     <= sum_e_r;
      car_s_r[0] <= car_e_r;
      for (int k = 1; k < ROOT_W; k++) begin
        sq_r[k]    <= sqrt_step(sq_r[k-1], x_r[k-1][SUM_W-1-2*k -: 2]);
        x_r[k]     <= x_r[k-1];
        car_s_r[k] <= car_s_r[k-1];
      end

      len_f_r <= sq_r[ROOT_W-1].root;
      car_f_r <= car_s_r[ROOT_W-1];

      drem_r <= drem_nxt;
      quo_r  <= quo_nxt;
      dlen_r <= dlen_in;
      dneg_r[0]  <= car_f_r.neg;
      dzero_r[0] <= car_f_r.zero;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dneg_r[k]  <= dneg_r[k-1];
        dzero_r[k] <= dzero_r[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        if (dzero_r[DIV_STEPS-1]) begin
          unit_r[i] <= '0;
        end else if (dneg_r[DIV_STEPS-1][i]) begin
          unit_r[i] <= -NORM_BITS'(quo_r[DIV_STEPS-1][i]);
        end else begin
          unit_r[i] <= NORM_BITS'(quo_r[DIV_STEPS-1][i]);
        end
      end
    end
  end

  assign unit = unit_r;

endmodule

@@ rtl/ppls_pow.sv @@
// Specular power pipeline: one fixed-point multiply per stage, stage k active when k < exponent.
module ppls_pow (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ppls_pkg::OUT_W-1:0]    base,
  input  logic [ppls_pkg::EXP_BITS-1:0] expo,
  input  ppls_pkg::pow_side_t           side_in,
  output logic [ppls_pkg::OUT_W-1:0]    pwr,
  output ppls_pkg::pow_side_t           side_out
);
  import ppls_pkg::*;

  logic [POW_STEPS-1:0][OUT_W-1:0]    p_r, c_r, p_nxt, p_in, c_in;
  logic [POW_STEPS-1:0][EXP_BITS-1:0] e_r, e_in;
  logic [POW_STEPS-1:0][2*OUT_W-1:0]  prod;
  pow_side_t                          s_r [POW_STEPS];

  always_comb begin
    for (int k = 0; k < POW_STEPS; k++) begin
      if (k == 0) begin
        p_in[k] = UNIT_ONE;
        c_in[k] = base;
        e_in[k] = expo;
      end else begin
        p_in[k] = p_r[k-1];
        c_in[k] = c_r[k-1];
        e_in[k] = e_r[k-1];
      end
      prod[k] = (2*OUT_W)'(p_in[k]) * (2*OUT_W)'(c_in[k]);
      p_nxt[k] = (EXP_BITS'(k) < e_in[k]) ? prod[k][COLOR_BITS +: OUT_W] : p_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      c_r    <= c_in;
      e_r    <= e_in;
      s_r[0] <= side_in;
      for (int k = 1; k < POW_STEPS; k++) begin
        s_r[k] <= s_r[k-1];
      end
    end
  end

  assign pwr      = p_r[POW_STEPS-1];
  assign side_out = s_r[POW_STEPS-1];

endmodule

@@ rtl/phong_point_light_shade_core.sv @@
// Top level of the Phong point-light shading pipeline with its configuration registers.
//
// Input channel in_valid/in_stall/in_data carries one surface hit per request;
// output channel out_valid/out_stall/out_data returns one color increment per
// request, in order. A request is taken on an edge with valid high and stall low.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// Write registers only while no request is in flight.
// Path: each request passes through two 53-stage normalizer passes in sequence,
// light/eye vectors then the reflected ray, and a 255-stage specular power
// chain before out_valid rises.
// Throughput: one request per cycle while no result waits under out_stall.
// Stall: the whole pipeline holds while a result waits under out_stall, and
// in_stall follows that hold in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous): pipeline emptied, light and eye at origin,
// light color all ones.
module phong_point_light_shade_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ppls_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ppls_pkg::out_req_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [3*ppls_pkg::COLOR_BITS-1:0]   cfg_data
);
  import ppls_pkg::*;

  localparam int LNQ_W   = DOT_W - UNIT_FRAC;
  localparam int RP_W    = LNQ_W + 1 + NORM_BITS;
  localparam int DPROD_W = COLOR_BITS + DOT_W;

  typedef struct packed {
    logic [2:0][NORM_BITS-1:0]  nrm;
    logic [2:0][COLOR_BITS-1:0] surf;
    logic [COLOR_BITS-1:0]      kd;
    logic [COLOR_BITS-1:0]      ks;
    logic [EXP_BITS-1:0]        ex;
  } sa_t;

  typedef struct packed {
    uvec_t                 te;
    logic [2:0][OUT_W-1:0] diff;
    logic [COLOR_BITS-1:0] ks;
    logic [EXP_BITS-1:0]   ex;
  } sb_t;

  logic en;
  logic [TOTAL_LAT-1:0] v_r;

  logic signed [COORD_BITS-1:0] light_x_r, light_y_r, light_z_r;
  logic signed [COORD_BITS-1:0] eye_x_r, eye_y_r, eye_z_r;
  logic [3*COLOR_BITS-1:0]      light_rgb_r;
  logic [2:0][COLOR_BITS-1:0]   lc;

  in_req_t in_r;
  dvec_t   dl_r, de_r, rf_r;
  sa_t     sa2_r;
  sa_t     sa_r [NORM_LAT];
  uvec_t   tl, te, ur;

  logic signed [2*NORM_BITS-1:0] lnp_r [3];
  logic [2:0][COLOR_BITS-1:0]    t1_r, t2_r;
  uvec_t                         tl56_r, te56_r, tl57_r, te57_r, tl58_r, te58_r;
  logic [2:0][NORM_BITS-1:0]     n56_r, n57_r;
  logic [COLOR_BITS-1:0]         ks56_r, ks57_r, ks58_r;
  logic [EXP_BITS-1:0]           ex56_r, ex57_r, ex58_r;
  logic signed [DOT_W-1:0]       ln57_r;
  logic [2:0][OUT_W-1:0]         diff58_r, diff_nxt;
  logic signed [RP_W-1:0]        rp58_r [3];
  logic signed [LNQ_W-1:0]       lnq;
  logic [2:0][2*COLOR_BITS-1:0]  t1p, t2p;
  logic [2:0][DPROD_W-1:0]       dprod, dsh;
  logic signed [RP_W-1:0]        rr [3];

  sb_t sb59_r, sb113_r;
  sb_t sb_r [NORM_LAT];

  logic signed [2*NORM_BITS-1:0] rvp_r [3];
  logic signed [DOT_W-1:0]       rvs;
  logic [DOT_W-DOT_FRAC+COLOR_BITS-1:0] csh;
  logic [OUT_W-1:0]              c_r, c_nxt, pw;
  logic [EXP_BITS-1:0]           ex114_r;
  pow_side_t                     ps114_r, ps_o;

  logic [OUT_W-1:0]              s370_r;
  logic [2:0][OUT_W-1:0]         diff370_r;
  logic [OUT_W+COLOR_BITS-1:0]   sprod;
  logic [2:0][OUT_W+COLOR_BITS-1:0] lprod;
  logic [2:0][OUT_W:0]           tot;
  logic [2:0][OUT_W-1:0]         outc;
  out_req_t                      out_r;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = v_r[TOTAL_LAT-1];
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r   <= '0;
      light_y_r   <= '0;
      light_z_r   <= '0;
      eye_x_r     <= '0;
      eye_y_r     <= '0;
      eye_z_r     <= '0;
      light_rgb_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIGHT_X:   light_x_r   <= cfg_data[COORD_BITS-1:0];
        REG_LIGHT_Y:   light_y_r   <= cfg_data[COORD_BITS-1:0];
        REG_LIGHT_Z:   light_z_r   <= cfg_data[COORD_BITS-1:0];
        REG_EYE_X:     eye_x_r     <= cfg_data[COORD_BITS-1:0];
        REG_EYE_Y:     eye_y_r     <= cfg_data[COORD_BITS-1:0];
        REG_EYE_Z:     eye_z_r     <= cfg_data[COORD_BITS-1:0];
        REG_LIGHT_RGB: light_rgb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lc[i] = light_rgb_r[(2-i)*COLOR_BITS +: COLOR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[TOTAL_LAT-2:0], in_valid};
    end
  end

  ppls_norm u_norm_l (.clk(clk), .en(en), .vec(dl_r), .unit(tl));
  ppls_norm u_norm_e (.clk(clk), .en(en), .vec(de_r), .unit(te));
  ppls_norm u_norm_r (.clk(clk), .en(en), .vec(rf_r), .unit(ur));

  // diffuse and reflection arithmetic
  always_comb begin
    lnq = LNQ_W'((ln57_r + DOT_W'(1 << (UNIT_FRAC-1))) >>> UNIT_FRAC);
    for (int i = 0; i < 3; i++) begin
      t1p[i]   = (2*COLOR_BITS)'(sa_r[NORM_LAT-1].kd) * (2*COLOR_BITS)'(sa_r[NORM_LAT-1].surf[i]);
      t2p[i]   = (2*COLOR_BITS)'(t1_r[i]) * (2*COLOR_BITS)'(lc[i]);
      dprod[i] = DPROD_W'(t2_r[i]) * DPROD_W'(ln57_r[DOT_W-2:0]);
      dsh[i]   = dprod[i] >> DOT_FRAC;
      if (ln57_r <= 0) begin
        diff_nxt[i] = '0;
      end else if (dsh[i] > DPROD_W'(SAT_MAX)) begin
        diff_nxt[i] = SAT_MAX;
      end else begin
        diff_nxt[i] = dsh[i][OUT_W-1:0];
      end
      rr[i] = (rp58_r[i] + RP_W'(1 << (UNIT_FRAC-1))) >>> UNIT_FRAC;
    end
  end

  // specular base and final mix
  always_comb begin
    rvs = DOT_W'(rvp_r[0]) + DOT_W'(rvp_r[1]) + DOT_W'(rvp_r[2]);
    csh = rvs[DOT_W-1:DOT_FRAC-COLOR_BITS];
    c_nxt = (csh > (DOT_W-DOT_FRAC+COLOR_BITS)'(UNIT_ONE)) ? UNIT_ONE : csh[OUT_W-1:0];
    sprod = (OUT_W+COLOR_BITS)'(ps_o.ks) * (OUT_W+COLOR_BITS)'(pw);
    for (int i = 0; i < 3; i++) begin
      lprod[i] = (OUT_W+COLOR_BITS)'(s370_r) * (OUT_W+COLOR_BITS)'(lc[i]);
      tot[i]   = (OUT_W+1)'(diff370_r[i]) + (OUT_W+1)'(lprod[i][COLOR_BITS +: OUT_W]);
      outc[i]  = (tot[i] > (OUT_W+1)'(SAT_MAX)) ? SAT_MAX : tot[i][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;

      dl_r[0] <= DIFF_W'(light_x_r) - DIFF_W'(in_r.hit_x);
      dl_r[1] <= DIFF_W'(light_y_r) - DIFF_W'(in_r.hit_y);
      dl_r[2] <= DIFF_W'(light_z_r) - DIFF_W'(in_r.hit_z);
      de_r[0] <= DIFF_W'(in_r.hit_x) - DIFF_W'(eye_x_r);
      de_r[1] <= DIFF_W'(in_r.hit_y) - DIFF_W'(eye_y_r);
      de_r[2] <= DIFF_W'(in_r.hit_z) - DIFF_W'(eye_z_r);
      sa2_r.nrm  <= {in_r.norm_z, in_r.norm_y, in_r.norm_x};
      sa2_r.surf <= {in_r.surf_blue, in_r.surf_green, in_r.surf_red};
      sa2_r.kd   <= in_r.diffuse_gain;
      sa2_r.ks   <= in_r.specular_gain;
      sa2_r.ex   <= in_r.shine_exponent;

      sa_r[0] <= sa2_r;
      sb_r[0] <= sb59_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        sa_r[k] <= sa_r[k-1];
        sb_r[k] <= sb_r[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        lnp_r[i] <= $signed(tl[i]) * $signed(sa_r[NORM_LAT-1].nrm[i]);
        t1_r[i]  <= t1p[i][2*COLOR_BITS-1:COLOR_BITS];
        t2_r[i]  <= t2p[i][2*COLOR_BITS-1:COLOR_BITS];
        rp58_r[i] <= (RP_W'(lnq) <<< 1) * RP_W'($signed(n57_r[i]));
        rf_r[i]  <= DIFF_W'($signed(tl58_r[i])) - DIFF_W'(rr[i]);
        rvp_r[i] <= $signed(ur[i]) * $signed(sb_r[NORM_LAT-1].te[i]);
      end
      tl56_r <= tl;
      te56_r <= te;
      n56_r  <= sa_r[NORM_LAT-1].nrm;
      ks56_r <= sa_r[NORM_LAT-1].ks;
      ex56_r <= sa_r[NORM_LAT-1].ex;

      ln57_r <= DOT_W'(lnp_r[0]) + DOT_W'(lnp_r[1]) + DOT_W'(lnp_r[2]);
      tl57_r <= tl56_r;
      te57_r <= te56_r;
      n57_r  <= n56_r;
      ks57_r <= ks56_r;
      ex57_r <= ex56_r;

      diff58_r <= diff_nxt;
      tl58_r   <= tl57_r;
      te58_r   <= te57_r;
      ks58_r   <= ks57_r;
      ex58_r   <= ex57_r;

      sb59_r.te   <= te58_r;
      sb59_r.diff <= diff58_r;
      sb59_r.ks   <= ks58_r;
      sb59_r.ex   <= ex58_r;

      sb113_r <= sb_r[NORM_LAT-1];

      c_r          <= c_nxt;
      ex114_r      <= sb113_r.ex;
      ps114_r.spen <= (rvs > 0);
      ps114_r.ks   <= sb113_r.ks;
      ps114_r.diff <= sb113_r.diff;

      s370_r    <= ps_o.spen ? sprod[COLOR_BITS +: OUT_W] : '0;
      diff370_r <= ps_o.diff;

      out_r.add_red   <= outc[0];
      out_r.add_green <= outc[1];
      out_r.add_blue  <= outc[2];
    end
  end

  ppls_pow u_pow (
    .clk      (clk),
    .en       (en),
    .base     (c_r),
    .expo     (ex114_r),
    .side_in  (ps114_r),
    .pwr      (pw),
    .side_out (ps_o)
  );

`ifndef SYNTH
  a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid pipe moved during hold");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a waiting result");

  a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[0]) |=> v_r[1])
    else $error("request dropped in pipe");

  a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted request not tracked");
`endif

endmodule
